@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/dpb_pkg.sv @@
// ----------------------------------------------------------------------------
// dpb_pkg
// Types and constants of the differential drive PI balance controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

   // Stream widths, padded to whole bytes, and the register index and data widths.
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 39;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KP            = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI            = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_MS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_POWER = 3'd5;

   // Register reset values.
   localparam logic [15:0] KP_RESET            = 16'd3277;
   localparam logic [31:0] KI_RESET            = 32'd4295;
   localparam logic [38:0] INTEGRAL_LIM_RESET  = 39'd10000000;
   localparam logic [31:0] START_TIME_RESET    = 32'd0;
   localparam logic [15:0] STARTUP_MS_RESET    = 16'd3500;
   localparam logic [7:0]  STARTUP_POWER_RESET = 8'd50;

   // Saturation caps of the integral step and the gain terms.
   localparam logic [64:0] PROD_CAP = 65'd1 << 40;
   localparam logic [61:0] TERM_CAP = 62'd1 << 61;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DT,
      ST_INT,
      ST_KP,
      ST_HI,
      ST_LO,
      ST_SUM
   } state_type;

endpackage

`default_nettype wire

@@ design/differential_drive_pi_balance.sv @@
// ----------------------------------------------------------------------------
// differential_drive_pi_balance
// PI balance controller for a two-wheel drive with a clamped integral,
// saturated right drive and a soft start window.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Content
// req      in         req_tvalid/req_tready  encoder counts, offset, power, time
// rsp      out        rsp_tvalid/rsp_tready  drives, reverse, error, saturation
// csr      in         csr_wr_en              register index and write data
//
// After its request is accepted, a result passes the steps DT, INT, KP, HI, LO
// and SUM before it is loaded into the output register: one 33x32 multiplier is
// shared by four products (error times elapsed time, error times kp, and the
// high and low halves of integral times ki). A request holds the sequencer until
// SUM loads its result. req_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the next request may start
// meanwhile and waits in its last step until that register is free.
// Reset is synchronous: it clears the sequencer, the output valid flag, the
// integral, the last timestamp and loads the register defaults.
//
`default_nettype none

module differential_drive_pi_balance (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: left_count[31:0], right_count[63:32], turn_offset[95:64],
   // drive_power[104:96], now_ms[136:105], zero fill above
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [dpb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: left_drive[7:0], right_drive[15:8], reverse[16],
   // balance_error[50:17], saturated[51], zero fill above
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [dpb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_wr_en,
   input  wire logic [dpb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import dpb_pkg::*;

   `include "assert_macros.svh"

   // Sequencer state.
   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] kp_ff, kp_in;
   logic [31:0] ki_ff, ki_in;
   logic [38:0] lim_ff, lim_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] startup_ms_ff, startup_ms_in;
   logic [7:0]  startup_pw_ff, startup_pw_in;

   // Controller state.
   logic signed [39:0] integral_ff, integral_in;
   logic [31:0]        last_time_ff, last_time_in;

   // Working registers of one transaction.
   logic signed [33:0] err_ff, err_in;
   logic [31:0]        dt_ff, dt_in;
   logic [31:0]        now_ff, now_in;
   logic signed [8:0]  power_ff, power_in;
   logic [64:0]        prod_ff, prod_in;
   logic [40:0]        hi_ff, hi_in;
   logic               hi_big_ff, hi_big_in;
   logic signed [62:0] pterm_ff, pterm_in;
   logic signed [62:0] iterm_ff, iterm_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_left_ff, rsp_left_in;
   logic [7:0]         rsp_right_ff, rsp_right_in;
   logic               rsp_reverse_ff, rsp_reverse_in;
   logic [33:0]        rsp_err_ff, rsp_err_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // Request fields.
   logic signed [31:0] req_left;
   logic signed [31:0] req_right;
   logic signed [31:0] req_offset;

   // Shared multiplier.
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] mul_p;

   // Derived magnitudes.
   logic [33:0] err_neg;
   logic [32:0] err_mag;
   logic [39:0] integral_neg;
   logic [38:0] integral_mag;
   logic [8:0]  power_mag;

   // Step intermediates.
   logic [40:0]        prod_capped;
   logic signed [41:0] prod_signed;
   logic signed [41:0] sum_raw;
   logic signed [41:0] lim_pos;
   logic signed [41:0] lim_neg;
   logic signed [41:0] sum_clamped;
   logic [61:0]        pterm_mag;
   logic [61:0]        iterm_raw;
   logic [61:0]        iterm_mag;
   logic signed [65:0] total;
   logic [7:0]         right_drive;
   logic               right_sat;
   logic [7:0]         left_drive;
   logic [31:0]        since_start;
   logic               in_window;
   logic               rsp_free;

   assign req_left   = req_tdata[31:0];
   assign req_right  = req_tdata[63:32];
   assign req_offset = req_tdata[95:64];

   // Magnitudes of the error, the integral and the commanded power.
   assign err_neg      = 34'd0 - err_ff;
   assign err_mag      = err_ff[33] ? err_neg[32:0] : err_ff[32:0];
   assign integral_neg = 40'd0 - integral_ff;
   assign integral_mag = integral_ff[39] ? integral_neg[38:0] : integral_ff[38:0];
   assign power_mag    = power_ff[8] ? 9'(9'd0 - power_ff) : power_ff;

   // Operand selection of the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_DT: begin
            mul_a = err_mag;
            mul_b = dt_ff;
         end
         ST_INT: begin
            mul_a = err_mag;
            mul_b = {16'd0, kp_ff};
         end
         ST_KP: begin
            mul_a = {14'd0, integral_mag[38:20]};
            mul_b = ki_ff;
         end
         ST_HI: begin
            mul_a = {13'd0, integral_mag[19:0]};
            mul_b = ki_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 65'(mul_a) * 65'(mul_b);

   // Integral step: capped product, signed add and symmetric clamp.
   always_comb begin
      prod_capped = (prod_ff > PROD_CAP) ? PROD_CAP[40:0] : prod_ff[40:0];
      prod_signed = err_ff[33] ? (42'sd0 - $signed({1'b0, prod_capped}))
                               : $signed({1'b0, prod_capped});
      sum_raw     = 42'(integral_ff) + prod_signed;
      lim_pos     = $signed({3'd0, lim_ff});
      lim_neg     = 42'sd0 - lim_pos;
      if (sum_raw > lim_pos) begin
         sum_clamped = lim_pos;
      end else if (sum_raw < lim_neg) begin
         sum_clamped = lim_neg;
      end else begin
         sum_clamped = sum_raw;
      end
   end

   // Gain terms in Q32, each capped at the term limit.
   always_comb begin
      pterm_mag = (|prod_ff[64:45]) ? TERM_CAP : {1'b0, prod_ff[44:0], 16'd0};
      iterm_raw = 62'({hi_ff, 20'd0}) + 62'(prod_ff[51:0]);
      iterm_mag = (hi_big_ff || (iterm_raw > TERM_CAP)) ? TERM_CAP : iterm_raw;
   end

   // Final sum, right drive saturation and the soft start window.
   always_comb begin
      total = $signed({25'd0, power_mag, 32'd0}) + 66'(pterm_ff) + 66'(iterm_ff);
      if (total[65]) begin
         right_drive = 8'd0;
         right_sat   = 1'b1;
      end else if (|total[65:40]) begin
         right_drive = 8'hFF;
         right_sat   = 1'b1;
      end else begin
         right_drive = total[39:32];
         right_sat   = 1'b0;
      end
      left_drive  = power_mag[8] ? 8'hFF : power_mag[7:0];
      since_start = now_ff - start_ff;
      in_window   = (since_start <= {16'd0, startup_ms_ff});
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Sequencer, datapath and configuration next values.
   always_comb begin
      state_in       = state_ff;
      kp_in          = kp_ff;
      ki_in          = ki_ff;
      lim_in         = lim_ff;
      start_in       = start_ff;
      startup_ms_in  = startup_ms_ff;
      startup_pw_in  = startup_pw_ff;
      integral_in    = integral_ff;
      last_time_in   = last_time_ff;
      err_in         = err_ff;
      dt_in          = dt_ff;
      now_in         = now_ff;
      power_in       = power_ff;
      prod_in        = prod_ff;
      hi_in          = hi_ff;
      hi_big_in      = hi_big_ff;
      pterm_in       = pterm_ff;
      iterm_in       = iterm_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_reverse_in = rsp_reverse_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_sat_in     = rsp_sat_ff;
      req_tready     = (state_ff == ST_IDLE);

      // Register writes.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KP:            kp_in         = csr_wdata[15:0];
            CSR_KI:            ki_in         = csr_wdata[31:0];
            CSR_INTEGRAL_LIM:  lim_in        = csr_wdata[38:0];
            CSR_START_TIME:    start_in      = csr_wdata[31:0];
            CSR_STARTUP_MS:    startup_ms_in = csr_wdata[15:0];
            CSR_STARTUP_POWER: startup_pw_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      // A taken result empties the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               err_in       = 34'(req_left) - 34'(req_right) - 34'(req_offset);
               dt_in        = req_tdata[136:105] - last_time_ff;
               now_in       = req_tdata[136:105];
               last_time_in = req_tdata[136:105];
               power_in     = req_tdata[104:96];
               state_in     = ST_DT;
            end
         end
         ST_DT: begin
            prod_in  = mul_p;
            state_in = ST_INT;
         end
         ST_INT: begin
            integral_in = sum_clamped[39:0];
            prod_in     = mul_p;
            state_in    = ST_KP;
         end
         ST_KP: begin
            pterm_in = err_ff[33] ? (63'sd0 - $signed({1'b0, pterm_mag}))
                                  : $signed({1'b0, pterm_mag});
            prod_in  = mul_p;
            state_in = ST_HI;
         end
         ST_HI: begin
            hi_big_in = |prod_ff[64:41];
            hi_in     = prod_ff[40:0];
            prod_in   = mul_p;
            state_in  = ST_LO;
         end
         ST_LO: begin
            iterm_in = integral_ff[39] ? (63'sd0 - $signed({1'b0, iterm_mag}))
                                       : $signed({1'b0, iterm_mag});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Hold here until the output register can take the result.
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_reverse_in = power_ff[8];
               rsp_err_in     = err_ff;
               if (in_window) begin
                  rsp_left_in  = startup_pw_ff;
                  rsp_right_in = startup_pw_ff;
                  rsp_sat_in   = 1'b0;
               end else begin
                  rsp_left_in  = left_drive;
                  rsp_right_in = right_drive;
                  rsp_sat_in   = right_sat;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control, configuration and controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         kp_ff         <= KP_RESET;
         ki_ff         <= KI_RESET;
         lim_ff        <= INTEGRAL_LIM_RESET;
         start_ff      <= START_TIME_RESET;
         startup_ms_ff <= STARTUP_MS_RESET;
         startup_pw_ff <= STARTUP_POWER_RESET;
         integral_ff   <= '0;
         last_time_ff  <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         lim_ff        <= lim_in;
         start_ff      <= start_in;
         startup_ms_ff <= startup_ms_in;
         startup_pw_ff <= startup_pw_in;
         integral_ff   <= integral_in;
         last_time_ff  <= last_time_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      dt_ff          <= dt_in;
      now_ff         <= now_in;
      power_ff       <= power_in;
      prod_ff        <= prod_in;
      hi_ff          <= hi_in;
      hi_big_ff      <= hi_big_in;
      pterm_ff       <= pterm_in;
      iterm_ff       <= iterm_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_right_ff   <= rsp_right_in;
      rsp_reverse_ff <= rsp_reverse_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_sat_ff     <= rsp_sat_in;
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_sat_ff, rsp_err_ff, rsp_reverse_ff,
                        rsp_right_ff, rsp_left_ff};

   // An accepted request starts the multiply sequence.
   `ASSERT_AT(a_accept_starts, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == ST_DT),
      "accepted request did not start the sequence")

   // A result that is not taken holds the sequencer in its last step.
   `ASSERT_AT(a_sum_waits, clock, reset,
      (state_ff == ST_SUM && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_SUM),
      "result overwrote a pending output")

   // A loaded result carries the direction of the current request.
   `ASSERT_AT(a_reverse_loaded, clock, reset,
      (state_ff == ST_SUM && rsp_free) |=>
         (rsp_valid_ff && rsp_reverse_ff == $past(power_ff[8])),
      "reverse flag does not follow power sign")

   // No request is taken while a transaction is in the sequence.
   `ASSERT_NEVER(a_busy_not_ready, clock, reset,
      (state_ff != ST_IDLE) && req_tready,
      "request ready while busy")

endmodule

`default_nettype wire
